/* rtl/core/qps_pkg.sv */
// Shared types, field widths, codes and reset values for the quadrature
// position servo core. No dependencies; every other file imports it.
`timescale 1ns / 1ps

package qps_pkg;

   localparam int COUNT_BITS_DEFAULT    = 32;
   localparam int INTEGRAL_BITS_DEFAULT = 48;

   localparam int POS_BITS       = 32;
   localparam int TARGET_BITS    = 32;
   localparam int GAIN_BITS      = 28;
   localparam int GAIN_FRAC      = 24;
   localparam int TOL_BITS       = 16;
   localparam int TOL_FRAC       = 16;
   localparam int LIMIT_BITS     = 16;
   localparam int BAND_BITS      = TOL_BITS + TARGET_BITS;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = GAIN_BITS;

   // Item function codes.
   localparam logic [1:0] FUNC_EDGE_A = 2'd0;
   localparam logic [1:0] FUNC_EDGE_B = 2'd1;
   localparam logic [1:0] FUNC_TICK   = 2'd2;
   localparam logic [1:0] FUNC_CLEAR  = 2'd3;

   // Register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PROP_GAIN    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INTEG_GAIN   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOLERANCE    = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EFFORT_LIMIT = 2'd3;

   localparam logic [GAIN_BITS-1:0]  PROP_GAIN_RESET    = 28'd10905190;
   localparam logic [GAIN_BITS-1:0]  INTEG_GAIN_RESET   = 28'd4194;
   localparam logic [TOL_BITS-1:0]   TOLERANCE_RESET    = 16'd66;
   localparam logic [LIMIT_BITS-1:0] EFFORT_LIMIT_RESET = 16'd400;

   typedef struct packed {
      logic [1:0]                    func;
      logic                          level_a;
      logic                          level_b;
      logic signed [TARGET_BITS-1:0] target;
   } req_type;

   typedef struct packed {
      logic signed [POS_BITS-1:0] position;
      logic [LIMIT_BITS-1:0]      drive;
      logic                       forward;
      logic                       arrived;
      logic                       is_control;
   } rsp_type;

   typedef struct packed {
      logic [GAIN_BITS-1:0]  prop_gain;
      logic [GAIN_BITS-1:0]  integ_gain;
      logic [TOL_BITS-1:0]   tolerance;
      logic [LIMIT_BITS-1:0] effort_limit;
   } cfg_type;

   // Load enables of the pipeline registers from the second stage on.
   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
      logic s5;
      logic s6;
      logic out;
   } stage_en_type;

   // Result fields known once the state update has been made.
   typedef struct packed {
      logic signed [POS_BITS-1:0] position;
      logic                       arrived;
      logic                       is_control;
   } side_type;

   function automatic int max_int(int a, int b);
      return (a > b) ? a : b;
   endfunction

endpackage

/* rtl/core/qps_csr.sv */
// Configuration registers of the servo core: gains, arrival tolerance and
// effort limit. Depends on qps_pkg.
`timescale 1ns / 1ps

module qps_csr import qps_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain    <= PROP_GAIN_RESET;
         cfg_ff.integ_gain   <= INTEG_GAIN_RESET;
         cfg_ff.tolerance    <= TOLERANCE_RESET;
         cfg_ff.effort_limit <= EFFORT_LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PROP_GAIN:    cfg_ff.prop_gain    <= csr_data;
            CSR_INTEG_GAIN:   cfg_ff.integ_gain   <= csr_data;
            CSR_TOLERANCE:    cfg_ff.tolerance    <= csr_data[TOL_BITS-1:0];
            CSR_EFFORT_LIMIT: cfg_ff.effort_limit <= csr_data[LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

endmodule

/* rtl/core/qps_tracker.sv */
// Position count and error integral: the one stage whose state feeds back.
// Forms the error, the arrival test and the saturating integral update.
// Depends on qps_pkg.
`timescale 1ns / 1ps

module qps_tracker import qps_pkg::*; #(
   parameter int COUNT_BITS    = COUNT_BITS_DEFAULT,
   parameter int INTEGRAL_BITS = INTEGRAL_BITS_DEFAULT,
   parameter int EW            = max_int(TARGET_BITS, COUNT_BITS) + 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  stage_en_type                    en,
   input  logic                            item_valid,
   input  req_type                         item,
   input  logic [BAND_BITS-1:0]            band,
   output side_type                        side,
   output logic signed [EW-1:0]            err,
   output logic signed [INTEGRAL_BITS-1:0] integ_old
);

   localparam int SW = max_int(INTEGRAL_BITS, EW) + 1;

   logic signed [COUNT_BITS-1:0]    count_ff, count_in;
   logic signed [INTEGRAL_BITS-1:0] integ_ff, integ_in;
   logic signed [EW-1:0]            err_in, err_ff;
   logic [EW-1:0]                   aerr;
   logic signed [SW-1:0]            isum;
   logic                            same, near, isum_fits, upd;
   logic                            arrived_in, ctrl_in;
   side_type                        side_ff;
   logic signed [INTEGRAL_BITS-1:0] integ_old_ff;

   assign upd       = en.s3 && item_valid;
   assign side      = side_ff;
   assign err       = err_ff;
   assign integ_old = integ_old_ff;

   always_comb begin
      same   = item.level_a == item.level_b;
      err_in = EW'($signed(item.target)) - EW'(count_ff);
      aerr   = err_in[EW-1] ? $unsigned(-err_in) : $unsigned(err_in);
      // An error of 2^31 or more can never lie inside the band.
      near   = (aerr[EW-1:TARGET_BITS-1] == '0) &&
               (BAND_BITS'({aerr[TARGET_BITS-2:0], {TOL_FRAC{1'b0}}}) <= band);
      isum      = SW'(integ_ff) + SW'(err_in);
      isum_fits = (&isum[SW-1:INTEGRAL_BITS-1]) || !(|isum[SW-1:INTEGRAL_BITS-1]);

      count_in   = count_ff;
      integ_in   = integ_ff;
      arrived_in = 1'b0;
      ctrl_in    = 1'b0;
      unique case (item.func)
         FUNC_EDGE_A: begin
            count_in = same ? count_ff - COUNT_BITS'(1) : count_ff + COUNT_BITS'(1);
         end
         FUNC_EDGE_B: begin
            count_in = same ? count_ff + COUNT_BITS'(1) : count_ff - COUNT_BITS'(1);
         end
         FUNC_TICK: begin
            ctrl_in = 1'b1;
            if (near) begin
               arrived_in = 1'b1;
               integ_in   = '0;
            end else if (isum_fits) begin
               integ_in = $signed(isum[INTEGRAL_BITS-1:0]);
            end else if (isum[SW-1]) begin
               integ_in = $signed({1'b1, {(INTEGRAL_BITS-1){1'b0}}});
            end else begin
               integ_in = $signed({1'b0, {(INTEGRAL_BITS-1){1'b1}}});
            end
         end
         FUNC_CLEAR: begin
            count_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         integ_ff <= '0;
      end else if (upd) begin
         count_ff <= count_in;
         integ_ff <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         side_ff.position   <= POS_BITS'(count_in);
         side_ff.arrived    <= arrived_in;
         side_ff.is_control <= ctrl_in;
         err_ff             <= err_in;
         integ_old_ff       <= integ_ff;
      end
   end

`ifndef ASSERT_OFF
   a_arrival_clears: assert property (@(posedge clock) disable iff (reset)
      upd && arrived_in |=> integ_ff == '0)
      else $error("integral not cleared on arrival");
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !upd |=> $stable(count_ff) && $stable(integ_ff))
      else $error("state changed without an item");
   a_clear_count: assert property (@(posedge clock) disable iff (reset)
      upd && item.func == FUNC_CLEAR |=> count_ff == '0)
      else $error("count not cleared");
`endif

endmodule

/* rtl/core/qps_mul.sv */
// Two-stage signed multiplier of an unsigned gain by a signed operand,
// split into two partial products. Depends on qps_pkg.
`timescale 1ns / 1ps

module qps_mul import qps_pkg::*; #(
   parameter int W = 33
) (
   input  logic                          clock,
   input  stage_en_type                  en,
   input  logic [GAIN_BITS-1:0]          gain,
   input  logic signed [W-1:0]           operand,
   output logic signed [W+GAIN_BITS-1:0] product
);

   localparam int LO = W / 2;
   localparam int HI = W - LO;
   localparam int PW = W + GAIN_BITS;

   logic [GAIN_BITS+LO-1:0]      pp_lo_in, pp_lo_ff;
   logic signed [GAIN_BITS+HI:0] pp_hi_in, pp_hi_ff;
   logic signed [PW-1:0]         product_in, product_ff;

   assign product = product_ff;

   always_comb begin
      pp_lo_in   = (GAIN_BITS + LO)'(gain) * (GAIN_BITS + LO)'(operand[LO-1:0]);
      pp_hi_in   = $signed({1'b0, gain}) * $signed(operand[W-1:LO]);
      product_in = (PW'(pp_hi_ff) <<< LO) + $signed({{HI{1'b0}}, pp_lo_ff});
   end

   always_ff @(posedge clock) begin
      if (en.s4) begin
         pp_lo_ff <= pp_lo_in;
         pp_hi_ff <= pp_hi_in;
      end
      if (en.s5) begin
         product_ff <= product_in;
      end
   end

endmodule

/* rtl/core/qps_effort.sv */
// Effort stages: sums the two gain products, truncates toward zero and
// splits into clamped magnitude and direction. Depends on qps_pkg.
`timescale 1ns / 1ps

module qps_effort import qps_pkg::*; #(
   parameter int EW = 33,
   parameter int IB = INTEGRAL_BITS_DEFAULT
) (
   input  logic                           clock,
   input  stage_en_type                   en,
   input  logic signed [EW+GAIN_BITS-1:0] prod_p,
   input  logic signed [IB+GAIN_BITS-1:0] prod_i,
   input  logic                           active,
   input  logic [LIMIT_BITS-1:0]          limit,
   output logic [LIMIT_BITS-1:0]          drive,
   output logic                           forward
);

   localparam int SUMW = max_int(EW, IB) + GAIN_BITS + 1;
   localparam int QW   = SUMW - GAIN_FRAC;

   logic signed [SUMW-1:0] sum_in, sum_ff;
   logic [SUMW-1:0]        mag;
   logic [QW-1:0]          q;
   logic                   neg;
   logic [LIMIT_BITS-1:0]  drive_in, drive_ff;
   logic                   forward_in, forward_ff;

   assign drive   = drive_ff;
   assign forward = forward_ff;

   always_comb begin
      sum_in = SUMW'(prod_p) + SUMW'(prod_i);
      neg    = sum_ff[SUMW-1];
      mag    = neg ? $unsigned(-sum_ff) : $unsigned(sum_ff);
      q      = mag[SUMW-1:GAIN_FRAC];
      if (!active) begin
         drive_in = '0;
      end else if (q > QW'(limit)) begin
         drive_in = limit;
      end else begin
         drive_in = q[LIMIT_BITS-1:0];
      end
      // A negative effort that truncates to zero still counts as forward.
      forward_in = !(active && neg && (|q));
   end

   always_ff @(posedge clock) begin
      if (en.s6) begin
         sum_ff <= sum_in;
      end
      if (en.out) begin
         drive_ff   <= drive_in;
         forward_ff <= forward_in;
      end
   end

endmodule

/* rtl/core/quadrature_pi_position_servo_core.sv */
// Quadrature position counter with a PI position loop, one item per clock
// unless the receiver stalls. Channels: req_valid/req_stall/req_data take
// items (encoder edge on A or B, control tick with a target, clear count);
// rsp_valid/rsp_stall/rsp_data give one result per item: the position
// after it and, on ticks, drive, direction and arrival. csr_valid/
// csr_ready/csr_index/csr_data write the gains, tolerance and effort
// limit; write them only while no item is in flight.
// Throughput is one item per cycle while the receiver does not stall. From
// acceptance to rsp_valid an item passes a band stage (tolerance times
// |target|), the count and integral update, two stages per gain multiplier,
// the sum, then the truncation and clamp into the output register. The
// count and integral feedback closes within the update stage, so a tick
// may directly follow an edge.
// Reset clears the count, the integral, the pipeline and the registers to
// their defaults. When the receiver stalls, the result holds and the
// pipeline keeps filling its empty stages; req_stall rises only once every
// stage holds an item.
// Depends on qps_pkg, qps_csr, qps_tracker, qps_mul and qps_effort.
`timescale 1ns / 1ps

module quadrature_pi_position_servo_core import qps_pkg::*; #(
   parameter int COUNT_BITS    = COUNT_BITS_DEFAULT,
   parameter int INTEGRAL_BITS = INTEGRAL_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int EW = max_int(TARGET_BITS, COUNT_BITS) + 1;

   cfg_type      cfg;
   stage_en_type en;
   logic         adv1, adv2, adv3, adv4, adv5, adv6, adv_out;
   logic         v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, out_v_ff;

   req_type                         item1_ff, item2_ff;
   logic [TARGET_BITS-1:0]          mag_t;
   logic [BAND_BITS-1:0]            band_in, band_ff;
   side_type                        side3, side4_ff, side5_ff, side6_ff, side_o_ff;
   logic signed [EW-1:0]            err3;
   logic signed [INTEGRAL_BITS-1:0] integ3;
   logic signed [EW+GAIN_BITS-1:0]            prod_p;
   logic signed [INTEGRAL_BITS+GAIN_BITS-1:0] prod_i;
   logic [LIMIT_BITS-1:0]           drive;
   logic                            forward;

   // A stage takes a new item when it is empty or its item moves on.
   always_comb begin
      adv_out   = !out_v_ff || !rsp_stall;
      adv6      = !v6_ff || adv_out;
      adv5      = !v5_ff || adv6;
      adv4      = !v4_ff || adv5;
      adv3      = !v3_ff || adv4;
      adv2      = !v2_ff || adv3;
      adv1      = !v1_ff || adv2;
      req_stall = !adv1;
      en.s2     = adv2;
      en.s3     = adv3;
      en.s4     = adv4;
      en.s5     = adv5;
      en.s6     = adv6;
      en.out    = adv_out;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         v5_ff    <= 1'b0;
         v6_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (adv1)    v1_ff    <= req_valid;
         if (adv2)    v2_ff    <= v1_ff;
         if (adv3)    v3_ff    <= v2_ff;
         if (adv4)    v4_ff    <= v3_ff;
         if (adv5)    v5_ff    <= v4_ff;
         if (adv6)    v6_ff    <= v5_ff;
         if (adv_out) out_v_ff <= v6_ff;
      end
   end

   qps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Arrival band, from the tolerance and the target alone.
   always_comb begin
      mag_t   = item1_ff.target[TARGET_BITS-1] ? $unsigned(-item1_ff.target)
                                               : $unsigned(item1_ff.target);
      band_in = BAND_BITS'(cfg.tolerance) * BAND_BITS'(mag_t);
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         item1_ff <= req_data;
      end
      if (en.s2) begin
         item2_ff <= item1_ff;
         band_ff  <= band_in;
      end
      if (en.s4)  side4_ff  <= side3;
      if (en.s5)  side5_ff  <= side4_ff;
      if (en.s6)  side6_ff  <= side5_ff;
      if (en.out) side_o_ff <= side6_ff;
   end

   qps_tracker #(
      .COUNT_BITS    (COUNT_BITS),
      .INTEGRAL_BITS (INTEGRAL_BITS),
      .EW            (EW)
   ) u_tracker (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .item_valid (v2_ff),
      .item       (item2_ff),
      .band       (band_ff),
      .side       (side3),
      .err        (err3),
      .integ_old  (integ3)
   );

   qps_mul #(.W(EW)) u_mul_prop (
      .clock   (clock),
      .en      (en),
      .gain    (cfg.prop_gain),
      .operand (err3),
      .product (prod_p)
   );

   qps_mul #(.W(INTEGRAL_BITS)) u_mul_integ (
      .clock   (clock),
      .en      (en),
      .gain    (cfg.integ_gain),
      .operand (integ3),
      .product (prod_i)
   );

   qps_effort #(
      .EW (EW),
      .IB (INTEGRAL_BITS)
   ) u_effort (
      .clock   (clock),
      .en      (en),
      .prod_p  (prod_p),
      .prod_i  (prod_i),
      .active  (side6_ff.is_control && !side6_ff.arrived),
      .limit   (cfg.effort_limit),
      .drive   (drive),
      .forward (forward)
   );

   assign rsp_valid           = out_v_ff;
   assign rsp_data.position   = side_o_ff.position;
   assign rsp_data.drive      = drive;
   assign rsp_data.forward    = forward;
   assign rsp_data.arrived    = side_o_ff.arrived;
   assign rsp_data.is_control = side_o_ff.is_control;

`ifndef ASSERT_OFF
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while the pipeline has room");
   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (!rsp_data.is_control || rsp_data.arrived) |->
         rsp_data.drive == '0 && rsp_data.forward)
      else $error("drive given without an active control tick");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule

/* sim/quadrature_pi_position_servo_core_tb.sv */
// Self-checking testbench for quadrature_pi_position_servo_core: drives encoder edges,
// control ticks and count clears, predicts every result and checks it as it arrives.
// Depends on qps_pkg and the core RTL; needs no files or arguments.
`timescale 1ns / 1ps

module quadrature_pi_position_servo_core_tb;
   import qps_pkg::*;

   localparam int     ITEMS_PER_PHASE = 400;
   localparam int     HOLD_CYCLES     = 400;
   localparam int     MAX_REPORTS     = 30;
   localparam longint INTEG_MAX = (longint'(1) <<< (INTEGRAL_BITS_DEFAULT - 1)) - 1;
   localparam longint INTEG_MIN = -INTEG_MAX - 1;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data  = '0;

   // Predicted state of the servo.
   logic signed [POS_BITS-1:0]              pred_count;
   logic signed [INTEGRAL_BITS_DEFAULT-1:0] pred_integral;
   cfg_type                                 pred_cfg;
   rsp_type                                 expected_results[$];

   int  send_idle_pct = 0;
   int  stall_pct     = 0;
   bit  hold_req      = 1'b0;
   int  hold_left     = 0;
   int  mismatches    = 0;
   int  items_sent    = 0;
   int  ticks_sent    = 0;
   int  arrivals      = 0;
   int  reg_writes    = 0;

   // Encoder pin levels and direction of the current quadrature burst.
   logic enc_a      = 1'b0;
   logic enc_b      = 1'b0;
   bit   burst_up   = 1'b1;
   int   burst_left = 0;

   always #5 clock = ~clock;

   quadrature_pi_position_servo_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   function automatic rsp_type predict_servo_result(req_type item);
      rsp_type                 res;
      logic                    same;
      longint                  tgt, err, aerr, atgt, tol_w, isum;
      logic signed [127:0]     g_p, g_i, e_w, i_w, effort, mag;
      logic [127:0]            q;
      res.drive      = '0;
      res.forward    = 1'b1;
      res.arrived    = 1'b0;
      res.is_control = 1'b0;
      same = (item.level_a == item.level_b);
      case (item.func)
         FUNC_EDGE_A: pred_count = same ? pred_count - 1 : pred_count + 1;
         FUNC_EDGE_B: pred_count = same ? pred_count + 1 : pred_count - 1;
         FUNC_CLEAR:  pred_count = '0;
         default: begin
            res.is_control = 1'b1;
            tgt   = longint'(item.target);
            err   = tgt - longint'(pred_count);
            aerr  = (err < 0) ? -err : err;
            atgt  = (tgt < 0) ? -tgt : tgt;
            tol_w = longint'(pred_cfg.tolerance);
            if (aerr * 65536 <= tol_w * atgt) begin
               res.arrived   = 1'b1;
               pred_integral = '0;
            end else begin
               g_p    = {100'd0, pred_cfg.prop_gain};
               g_i    = {100'd0, pred_cfg.integ_gain};
               e_w    = 128'(err);
               i_w    = 128'(pred_integral);
               effort = g_p * e_w + g_i * i_w;
               mag    = (effort < 0) ? -effort : effort;
               q      = mag;
               q      = q >> GAIN_FRAC;
               if (effort < 0 && q != 0)
                  res.forward = 1'b0;
               res.drive = (q > pred_cfg.effort_limit) ? pred_cfg.effort_limit
                                                       : q[LIMIT_BITS-1:0];
               isum = longint'(pred_integral);
               isum = isum + err;
               if (isum > INTEG_MAX)
                  isum = INTEG_MAX;
               else if (isum < INTEG_MIN)
                  isum = INTEG_MIN;
               pred_integral = isum[INTEGRAL_BITS_DEFAULT-1:0];
            end
         end
      endcase
      res.position = pred_count;
      return res;
   endfunction

   function automatic req_type make_item(logic [1:0] f, logic a, logic b, logic [31:0] t);
      req_type item;
      item.func    = f;
      item.level_a = a;
      item.level_b = b;
      item.target  = t;
      return item;
   endfunction

   function automatic logic [31:0] pick_target();
      logic [31:0] t;
      case ($urandom_range(9))
         0, 1, 2: t = pred_count;
         3, 4:    t = pred_count + $urandom_range(40) - 20;
         5: begin
            case ($urandom_range(3))
               0:       t = 32'h7FFF_FFFF;
               1:       t = 32'h8000_0000;
               2:       t = 32'h0000_0000;
               default: t = 32'hFFFF_FFFF;
            endcase
         end
         6, 7:    t = $urandom;
         default: t = $urandom_range(2000) - 1000;
      endcase
      return t;
   endfunction

   // Mostly clean quadrature bursts in one direction, with ticks, stray edges and clears.
   function automatic req_type next_random_item();
      int         roll;
      logic [1:0] f;
      roll = $urandom_range(99);
      if (roll < 65) begin
         if (burst_left == 0) begin
            burst_up   = 1'($urandom_range(1));
            burst_left = $urandom_range(40, 4);
         end
         burst_left--;
         if ((enc_a == enc_b) == burst_up) begin
            enc_a = ~enc_a;
            f     = FUNC_EDGE_A;
         end else begin
            enc_b = ~enc_b;
            f     = FUNC_EDGE_B;
         end
         return make_item(f, enc_a, enc_b, $urandom);
      end
      if (roll < 88)
         return make_item(FUNC_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)),
                          pick_target());
      if (roll < 97) begin
         f = $urandom_range(1) ? FUNC_EDGE_B : FUNC_EDGE_A;
         return make_item(f, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
      end
      return make_item(FUNC_CLEAR, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
   endfunction

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_item(req_type item);
      rsp_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      res = predict_servo_result(item);
      expected_results.push_back(res);
      items_sent++;
      if (res.is_control)
         ticks_sent++;
      if (res.arrived)
         arrivals++;
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_PROP_GAIN:    pred_cfg.prop_gain    = val;
         CSR_INTEG_GAIN:   pred_cfg.integ_gain   = val;
         CSR_TOLERANCE:    pred_cfg.tolerance    = val[TOL_BITS-1:0];
         CSR_EFFORT_LIMIT: pred_cfg.effort_limit = val[LIMIT_BITS-1:0];
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
   endtask

   // Only called with nothing in flight.
   task automatic set_config(logic [CSR_DATA_BITS-1:0] prop, logic [CSR_DATA_BITS-1:0] integ,
                             logic [CSR_DATA_BITS-1:0] tol, logic [CSR_DATA_BITS-1:0] limit);
      write_reg(CSR_PROP_GAIN, prop);
      write_reg(CSR_INTEG_GAIN, integ);
      write_reg(CSR_TOLERANCE, tol);
      write_reg(CSR_EFFORT_LIMIT, limit);
      csr_valid <= 1'b0;
   endtask

   task automatic test_directed_cases();
      send_idle_pct = 0;
      stall_pct     = 0;
      // Both channels with every pair of sampled levels.
      for (int f = 0; f < 2; f++) begin
         for (int lv = 0; lv < 4; lv++)
            send_item(make_item((f == 0) ? FUNC_EDGE_A : FUNC_EDGE_B, lv[1], lv[0], $urandom));
      end
      repeat (3) send_item(make_item(FUNC_EDGE_A, 1'b1, 1'b1, $urandom));
      // A negative target reached exactly, then one count off with an effort below one.
      send_item(make_item(FUNC_TICK, 1'b0, 1'b1, -32'sd3));
      send_item(make_item(FUNC_TICK, 1'b1, 1'b0, -32'sd4));
      send_item(make_item(FUNC_TICK, 1'b1, 1'b1, 32'h7FFF_FFFF));
      send_item(make_item(FUNC_TICK, 1'b0, 1'b0, 32'h8000_0000));
      send_item(make_item(FUNC_CLEAR, 1'b0, 1'b1, $urandom));
      // A zero target arrives only with zero error.
      send_item(make_item(FUNC_TICK, 1'b0, 1'b0, 32'd0));
      send_item(make_item(FUNC_EDGE_A, 1'b0, 1'b1, $urandom));
      send_item(make_item(FUNC_TICK, 1'b1, 1'b1, 32'd0));
      send_item(make_item(FUNC_TICK, 1'b0, 1'b0, 32'd1));
      send_item(make_item(FUNC_CLEAR, 1'b1, 1'b1, $urandom));
      wait_for_results();
   endtask

   // With unit integral gain and no proportional term the drive shows the integral
   // before each tick up to the limit; results trace it growing and shrinking both ways.
   task automatic test_integral_growth();
      send_idle_pct = 0;
      stall_pct     = 0;
      set_config(28'd0, 28'd1 << GAIN_FRAC, CSR_DATA_BITS'(TOLERANCE_RESET), 28'hFFFF);
      send_item(make_item(FUNC_CLEAR, 1'b0, 1'b0, 32'd0));
      send_item(make_item(FUNC_TICK, 1'b0, 1'b0, 32'd0));
      repeat (12) send_item(make_item(FUNC_TICK, 1'b0, 1'b0, 32'h8000_0000));
      repeat (12) send_item(make_item(FUNC_TICK, 1'b0, 1'b0, 32'h7FFF_FFFF));
      repeat (24) send_item(make_item(FUNC_TICK, 1'b0, 1'b0, 32'd1000));
      send_item(make_item(FUNC_TICK, 1'b0, 1'b0, 32'd0));
      repeat (8) send_item(make_item(FUNC_TICK, 1'b0, 1'b0, -32'sd500));
      wait_for_results();
   endtask

   task automatic test_random_phase(int idle, int stall, logic [CSR_DATA_BITS-1:0] prop,
                                    logic [CSR_DATA_BITS-1:0] integ,
                                    logic [CSR_DATA_BITS-1:0] tol,
                                    logic [CSR_DATA_BITS-1:0] limit);
      set_config(prop, integ, tol, limit);
      send_idle_pct = idle;
      stall_pct     = stall;
      repeat (ITEMS_PER_PHASE) send_item(next_random_item());
      wait_for_results();
   endtask

   // The receiver holds off long enough for the pipeline to fill and stall the input.
   task automatic test_input_backpressure();
      set_config(CSR_DATA_BITS'($urandom), CSR_DATA_BITS'($urandom_range(20000)),
                 CSR_DATA_BITS'($urandom_range(2000)), CSR_DATA_BITS'($urandom_range(1000)));
      send_idle_pct = 0;
      stall_pct     = 0;
      @(posedge clock);
      hold_req = 1'b1;
      @(negedge clock);
      repeat (60) send_item(next_random_item());
      wait_for_results();
   endtask

   always @(negedge clock) begin
      if (hold_req) begin
         hold_left = HOLD_CYCLES;
         hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name,
                     $signed(want), $signed(got));
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t ns: result with nothing expected, expected none, got position %0d",
                        $time, rsp_data.position);
         end else begin
            want = expected_results.pop_front();
            check_field("position", want.position, rsp_data.position);
            check_field("drive", want.drive, rsp_data.drive);
            check_field("forward", want.forward, rsp_data.forward);
            check_field("arrived", want.arrived, rsp_data.arrived);
            check_field("is_control", want.is_control, rsp_data.is_control);
         end
      end
   end

   initial begin
      pred_count             = '0;
      pred_integral          = '0;
      pred_cfg.prop_gain     = PROP_GAIN_RESET;
      pred_cfg.integ_gain    = INTEG_GAIN_RESET;
      pred_cfg.tolerance     = TOLERANCE_RESET;
      pred_cfg.effort_limit  = EFFORT_LIMIT_RESET;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_cases();
      test_integral_growth();
      test_random_phase(0, 0, PROP_GAIN_RESET, INTEG_GAIN_RESET,
                        CSR_DATA_BITS'(TOLERANCE_RESET), CSR_DATA_BITS'(EFFORT_LIMIT_RESET));
      // Bits above the sixteen of tolerance and limit must be dropped.
      test_random_phase(88, 0, 28'hFFF_FFFF, 28'd0, 28'hFFF_FFFF, 28'hABC_FFFF);
      test_random_phase(0, 88, 28'd0, 28'hFFF_FFFF, 28'hFFF_0000, 28'd0);
      test_random_phase(8, 8, CSR_DATA_BITS'($urandom),
                        CSR_DATA_BITS'($urandom >> $urandom_range(31, 8)),
                        CSR_DATA_BITS'($urandom), CSR_DATA_BITS'($urandom));
      test_input_backpressure();

      stall_pct = 0;
      wait_for_results();
      repeat (20) @(negedge clock);

      $display("Covered %0d items (%0d control ticks, %0d arrivals) and %0d register writes,",
               items_sent, ticks_sent, arrivals, reg_writes);
      $display("including integral growth both ways, four idling mixes and a long hold.");
      if (mismatches == 0 && expected_results.size() == 0)
         $display("quadrature_pi_position_servo_core regression: pass");
      else
         $display("quadrature_pi_position_servo_core regression: fail");
      $finish;
   end

   initial begin
      #15_000_000;
      $display("Timed out with %0d results outstanding.", expected_results.size());
      $display("quadrature_pi_position_servo_core regression: fail");
      $finish;
   end

endmodule

/* files.f */
rtl/core/qps_pkg.sv
rtl/core/qps_csr.sv
rtl/core/qps_tracker.sv
rtl/core/qps_mul.sv
rtl/core/qps_effort.sv
rtl/core/quadrature_pi_position_servo_core.sv
sim/quadrature_pi_position_servo_core_tb.sv
